/* rtl/core/stsb_pkg.sv */
`default_nettype none

package stsb_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef logic               opcode_t;
	typedef logic [IDX_W-1:0]   index_t;
	typedef logic signed [DATA_W-1:0] value_t;
	typedef logic [CNT_W-1:0]   count_t;

	localparam opcode_t OP_WRITE  = 1'b0;
	localparam opcode_t OP_SEARCH = 1'b1;

	// Register index of entries_in_use in the configuration map.
	localparam logic REG_ENTRIES_IN_USE = 1'b0;

endpackage

`default_nettype wire

/* rtl/core/stsb_if.sv */
`default_nettype none

interface stsb_req_if;
	logic              valid;
	logic              ready;
	stsb_pkg::opcode_t opcode;
	stsb_pkg::index_t  entry_index;
	stsb_pkg::value_t  data_value;

	modport source (output valid, output opcode, output entry_index, output data_value,
		input ready);
	modport sink (input valid, input opcode, input entry_index, input data_value,
		output ready);
endinterface

interface stsb_rsp_if;
	logic             valid;
	logic             ready;
	logic             found;
	stsb_pkg::index_t position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

/* rtl/core/stsb_apb.sv */
`default_nettype none

module stsb_apb (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [stsb_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [stsb_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [stsb_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                     pready,
	output stsb_pkg::count_t                         entries_in_use
);

	stsb_pkg::count_t count_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	// Registers are 4 bytes apart; the low address bits do not matter.
	assign reg_sel = (paddr[2] == stsb_pkg::REG_ENTRIES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			count_q <= pwdata[stsb_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[stsb_pkg::CNT_W-1:0] = count_q;
		end
	end

	assign entries_in_use = count_q;

endmodule

`default_nettype wire

/* rtl/core/stsb_table.sv */
`default_nettype none

module stsb_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire stsb_pkg::value_t  wr_data,
	input  wire logic [AW-1:0]     rd_addr,
	output stsb_pkg::value_t       rd_data
);

	stsb_pkg::value_t mem_q [DEPTH];
	stsb_pkg::value_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/stsb_search.sv */
`default_nettype none

module stsb_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	stsb_req_if.sink              req,
	stsb_rsp_if.source            rsp,
	input  wire stsb_pkg::count_t entries_in_use,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output stsb_pkg::value_t      wr_data,
	output logic [AW-1:0]         rd_addr,
	input  wire stsb_pkg::value_t rd_data
);

	localparam int IDX_W = stsb_pkg::IDX_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PROBE = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    n_q;
	logic [AW-1:0]    mid_q;
	stsb_pkg::value_t key_q;
	logic             hit_q;
	logic             out_valid_q;
	logic             found_q;
	stsb_pkg::index_t position_q;

	logic             accept;
	logic [CW-1:0]    n_c;
	logic [CW-1:0]    mid_c;
	logic             out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Counts above the table depth cover the whole table.
	assign n_c = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
		: CW'(entries_in_use);

	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	// Writes go straight to the table; out-of-range indexes are dropped.
	assign wr_en   = accept && (req.opcode == stsb_pkg::OP_WRITE)
		&& (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr = AW'(req.entry_index);
	assign wr_data = req.data_value;

	assign rd_addr = (state_q == ST_PROBE && lo_q < hi_q) ? AW'(mid_c) : AW'(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.opcode == stsb_pkg::OP_SEARCH) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (lo_q < hi_q) begin
						state_q <= ST_CMP;
					end else if (lo_q < n_q) begin
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					state_q <= ST_PROBE;
				end
				ST_CHK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= req.data_value;
					n_q   <= n_c;
					lo_q  <= '0;
					hi_q  <= n_c;
					hit_q <= 1'b0;
				end
			end
			ST_PROBE: begin
				mid_q <= AW'(mid_c);
				hit_q <= 1'b0;
			end
			ST_CMP: begin
				if (rd_data < key_q) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			ST_CHK: begin
				hit_q <= (rd_data == key_q);
			end
			ST_DONE: begin
				if (out_free) begin
					found_q    <= hit_q;
					position_q <= hit_q ? IDX_W'(lo_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = found_q;
	assign rsp.position = position_q;

endmodule

`default_nettype wire

/* rtl/core/sorted_table_binary_search.sv */
`default_nettype none

// Sorted-table lower-bound search. The block keeps a table of TABLE_DEPTH signed
// 32-bit entries in a single memory. A word with opcode write stores data_value at
// entry_index and gives no result; an index at or beyond TABLE_DEPTH is dropped. A
// word with opcode search looks for data_value among the first entries_in_use
// entries (the APB register at address 0, capped at TABLE_DEPTH), which the user
// keeps sorted ascending, and returns one word with found and the position of the
// leftmost match (position is 0 when nothing matches). Every probe addresses the
// memory in one state and compares the registered read data in the next. The
// probes run one after another through the table memory read port and the single
// comparator. The input is ready only while no search is in flight; a finished
// result sits in an output register so the next word can be taken while it waits.
// Entries must be written before a search can reach them, and entries_in_use may
// change only while the block is idle.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	stsb_req_if.sink                             req,
	stsb_rsp_if.source                           rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [stsb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [stsb_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [stsb_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	localparam int AW = $clog2(TABLE_DEPTH);

	stsb_pkg::count_t entries_in_use;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	stsb_pkg::value_t wr_data;
	logic [AW-1:0]    rd_addr;
	stsb_pkg::value_t rd_data;

	// Configuration register file.
	stsb_apb u_apb (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.entries_in_use (entries_in_use)
	);

	// The table itself: one write and one registered read per cycle.
	stsb_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer that walks the probes with the shared comparator.
	stsb_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.entries_in_use (entries_in_use),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Testbench for the sorted-table binary search block.
//
// Request words either write one table entry or search for a key. A search makes
// exactly one response word, and a write makes none. A mirror of the table sits in
// the testbench and is updated at the edge where each write word is accepted; a
// mirror of the entries_in_use register is updated when the register is written.
// For every accepted search, the expected lower-bound result is computed right away
// and queued. The response checker pops the oldest expectation for each accepted
// response word and compares it field by field.
//
// A search must never reach a table entry that was never written. For that reason
// the directed tests only widen entries_in_use over entries they have written.
// The full-table test then writes the lower half of the table and puts the largest
// value right above it. Any search over the whole table probes that middle entry
// first and always turns into the written half, so from there on any count up to
// the half depth, and any count from the full depth up, is safe.
module testbench;

	localparam int TABLE_DEPTH     = 1024;
	localparam int FILL_DEPTH      = TABLE_DEPTH / 2;
	localparam int SETTLE_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT  = 5000;  // longer than the longest receiver hold-off
	localparam int RANDOM_PHASES   = 4;
	localparam int WORDS_PER_PHASE = 40;

	localparam stsb_pkg::value_t VALUE_MIN = 32'sh8000_0000;
	localparam stsb_pkg::value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic [stsb_pkg::APB_ADDR_W-1:0] ADDR_ENTRIES_IN_USE =
		stsb_pkg::APB_ADDR_W'(4 * stsb_pkg::REG_ENTRIES_IN_USE);

	typedef struct packed {
		logic             found;
		stsb_pkg::index_t position;
	} lookup_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [stsb_pkg::APB_ADDR_W-1:0] paddr;
	logic [stsb_pkg::APB_DATA_W-1:0] pwdata;
	logic [stsb_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	stsb_req_if req_if ();
	stsb_rsp_if rsp_if ();

	sorted_table_binary_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// This is the testbench's own view of the block state. The entries and the count
	// are updated on acceptance, in the same order in which the block sees them.
	stsb_pkg::value_t entry_mirror [TABLE_DEPTH];
	stsb_pkg::count_t count_mirror;
	lookup_t          pending_lookups [$];

	int mismatch_count;
	int burst_left;
	bit sender_idles;
	int hold_request;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// This reports one failure with the time, the expected and the actual value.
	function automatic void report_mismatch(string what, longint want, longint got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endfunction

	// The register holds 11 bits, but a search never covers more than the table.
	function automatic int effective_count();
		return (int'(count_mirror) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
	endfunction

	// This is the lower-bound search that the block runs. It halves [lo, hi) toward
	// the first entry that is not below the key, with one signed compare per probe.
	// It then reports a hit only when that entry equals the key. The same probe path
	// is followed when the table is not sorted.
	function automatic lookup_t lower_bound_lookup(stsb_pkg::value_t key);
		int n;
		int lo;
		int hi;
		int mid;
		lookup_t r;
		n = effective_count();
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (entry_mirror[mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		r.found = (lo < n) && (entry_mirror[lo] == key);
		r.position = r.found ? stsb_pkg::index_t'(lo) : '0;
		return r;
	endfunction

	// This returns a uniform value in [lo, hi]. A write that uses it keeps the table
	// sorted when its neighbors are sorted.
	function automatic stsb_pkg::value_t value_between(stsb_pkg::value_t lo,
			stsb_pkg::value_t hi);
		longint unsigned span;
		longint unsigned r;
		span = longint'(hi) - longint'(lo) + 1;
		r = {$urandom, $urandom};
		return stsb_pkg::value_t'(longint'(lo) + longint'(r % span));
	endfunction

	// Most search keys hit an entry in use or land right beside one. The rest are
	// fully random 32-bit values.
	function automatic stsb_pkg::value_t probe_key();
		int n;
		int pick;
		stsb_pkg::value_t base;
		n = effective_count();
		pick = $urandom_range(0, 9);
		if (n == 0 || pick >= 8)
			return stsb_pkg::value_t'($urandom);
		base = entry_mirror[$urandom_range(0, n - 1)];
		if (pick < 6)
			return base;
		return (pick == 6) ? base - 1 : base + 1;
	endfunction

	// This offers one request word and returns at the edge where the block accepts it.
	// The valid signal stays high after acceptance. The next call either keeps it high
	// for a back-to-back word or lowers it to open a gap between bursts.
	task automatic send_word(stsb_pkg::opcode_t op, stsb_pkg::index_t idx,
			stsb_pkg::value_t val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_idles ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_if.valid       <= 1'b1;
		req_if.opcode      <= op;
		req_if.entry_index <= idx;
		req_if.data_value  <= val;
		do @(posedge clk); while (!req_if.ready);
		burst_left--;
		if (op == stsb_pkg::OP_WRITE)
			entry_mirror[idx] = val;
		else
			pending_lookups.push_back(lower_bound_lookup(val));
	endtask

	task automatic search_word(stsb_pkg::value_t key);
		send_word(stsb_pkg::OP_SEARCH, stsb_pkg::index_t'($urandom), key);
	endtask

	// The sender stops and waits until every expected search result has come back.
	task automatic drain_lookups();
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_lookups.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [stsb_pkg::APB_ADDR_W-1:0] addr,
			logic [stsb_pkg::APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(logic [stsb_pkg::APB_ADDR_W-1:0] addr,
			output logic [stsb_pkg::APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// The count may only change while the block is idle. The task drains all results
	// first. It then waits long enough for a trailing table write to land, and only
	// then writes the register and reads it back.
	task automatic program_entries_in_use(stsb_pkg::count_t count);
		logic [stsb_pkg::APB_DATA_W-1:0] readback;
		drain_lookups();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(ADDR_ENTRIES_IN_USE, stsb_pkg::APB_DATA_W'(count));
		count_mirror = count;
		apb_read(ADDR_ENTRIES_IN_USE, readback);
		if (readback !== stsb_pkg::APB_DATA_W'(count))
			report_mismatch("entries_in_use readback", longint'(count), longint'(readback));
	endtask

	// With no entries in use, no entry is compared and nothing can match.
	task automatic test_empty_table();
		program_entries_in_use(stsb_pkg::count_t'(0));
		search_word(VALUE_MIN);
		search_word(stsb_pkg::value_t'(0));
		search_word(VALUE_MAX);
	endtask

	// A small hand-built table covers the following cases: both value extremes,
	// duplicates that must report the leftmost match, keys that fall between entries,
	// a key above every entry in use, a single-entry window, and a table that has been
	// made unsorted.
	task automatic test_directed_lookups();
		stsb_pkg::value_t seed_values [8];
		seed_values = '{VALUE_MIN, -32'sd5, -32'sd5, 32'sd0, 32'sd7, 32'sd7, 32'sd7, VALUE_MAX};
		for (int i = 0; i < 8; i++)
			send_word(stsb_pkg::OP_WRITE, stsb_pkg::index_t'(i), seed_values[i]);

		program_entries_in_use(stsb_pkg::count_t'(8));
		search_word(VALUE_MIN);
		search_word(-32'sd5);
		search_word(32'sd7);
		search_word(VALUE_MAX);
		search_word(32'sd3);
		search_word(-32'sd6);

		// The last entry in use is now 7, so these keys run past the end of the window.
		program_entries_in_use(stsb_pkg::count_t'(7));
		search_word(VALUE_MAX);
		search_word(32'sd100);

		program_entries_in_use(stsb_pkg::count_t'(1));
		search_word(VALUE_MIN);
		search_word(32'sd0);

		// This write breaks the ascending order. The probe path still decides the result.
		send_word(stsb_pkg::OP_WRITE, stsb_pkg::index_t'(2), 32'sd1000);
		program_entries_in_use(stsb_pkg::count_t'(8));
		search_word(32'sd1000);
		search_word(32'sd0);
	endtask

	// The lower half of the table is written once, in ascending order from the most
	// negative value, with runs of equal entries mixed in and the next-to-largest value
	// on top. The entry just above holds the largest value. The test covers the written
	// half as a window, then the full window, the largest count the register holds,
	// and a count just past the table, where both of the latter saturate to the depth.
	task automatic test_full_table();
		longint level;
		level = longint'(VALUE_MIN);
		for (int i = 0; i <= FILL_DEPTH; i++) begin
			if (i == FILL_DEPTH)
				level = longint'(VALUE_MAX);
			else if (i == FILL_DEPTH - 1)
				level = longint'(VALUE_MAX) - 1;
			else if (i != 0 && $urandom_range(0, 3) != 0)
				level += $urandom_range(1, 4000000);
			send_word(stsb_pkg::OP_WRITE, stsb_pkg::index_t'(i), stsb_pkg::value_t'(level));
		end

		program_entries_in_use(stsb_pkg::count_t'(FILL_DEPTH));
		search_word(VALUE_MIN);
		search_word(VALUE_MAX);
		search_word(VALUE_MAX - 1);
		for (int i = 0; i < 12; i++)
			search_word(probe_key());

		program_entries_in_use(stsb_pkg::count_t'(TABLE_DEPTH));
		search_word(VALUE_MAX);
		for (int i = 0; i < 6; i++)
			search_word(probe_key());

		program_entries_in_use('1);
		for (int i = 0; i < 4; i++)
			search_word(probe_key());

		program_entries_in_use(stsb_pkg::count_t'(TABLE_DEPTH + 1));
		for (int i = 0; i < 4; i++)
			search_word(probe_key());
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering words
	// back to back. Once the output register and the search in flight are both
	// occupied, the block has to stall its input.
	task automatic test_backpressure();
		program_entries_in_use(stsb_pkg::count_t'(16));
		sender_idles = 1'b0;
		hold_request = 300;
		for (int i = 0; i < 24; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_word(stsb_pkg::OP_WRITE,
					stsb_pkg::index_t'($urandom_range(16, FILL_DEPTH - 1)),
					stsb_pkg::value_t'($urandom));
			else
				search_word(probe_key());
		end
		drain_lookups();
		sender_idles = 1'b1;
	endtask

	// In the random phases, each phase picks a count and then runs a mix of writes and
	// searches. Most writes land inside the written part of the window with a value
	// between their neighbors, so the table stays mostly sorted and searches walk long
	// probe paths. The rest of the writes are noise that breaks the order.
	task automatic test_random_phases();
		int n;
		int w;
		int idx;
		stsb_pkg::value_t lo;
		stsb_pkg::value_t hi;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0:       program_entries_in_use(stsb_pkg::count_t'(0));
				1:       program_entries_in_use(stsb_pkg::count_t'(TABLE_DEPTH));
				2:       program_entries_in_use(
						stsb_pkg::count_t'($urandom_range(TABLE_DEPTH + 1, 2047)));
				3, 4, 5: program_entries_in_use(stsb_pkg::count_t'($urandom_range(17, 128)));
				default: program_entries_in_use(stsb_pkg::count_t'($urandom_range(1, 16)));
			endcase
			sender_idles = ($urandom_range(0, 4) != 0);
			n = effective_count();
			w = (n < FILL_DEPTH) ? n : FILL_DEPTH;
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if ($urandom_range(0, 99) < 35) begin
					if (w == 0 || $urandom_range(0, 9) == 0)
						idx = $urandom_range(0, FILL_DEPTH - 1);
					else
						idx = $urandom_range(0, w - 1);
					lo = (idx == 0) ? VALUE_MIN : entry_mirror[idx - 1];
					hi = (idx == TABLE_DEPTH - 1) ? VALUE_MAX : entry_mirror[idx + 1];
					if (lo <= hi && $urandom_range(0, 4) != 0)
						send_word(stsb_pkg::OP_WRITE, stsb_pkg::index_t'(idx),
							value_between(lo, hi));
					else
						send_word(stsb_pkg::OP_WRITE, stsb_pkg::index_t'(idx),
							stsb_pkg::value_t'($urandom));
				end else begin
					search_word(probe_key());
				end
			end
		end
		sender_idles = 1'b1;
	endtask

	// The receiver stalls in stretches of random length. Each stretch has its own
	// stall rate, and some stretches have no stalls at all. A hold-off that a test
	// requests takes priority, and this process counts it down on its own.
	initial begin
		int hold_left;
		int pattern_left;
		int stall_pct;
		hold_left = 0;
		pattern_left = 0;
		stall_pct = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(16, 96);
					case ($urandom_range(0, 4))
						0, 1:    stall_pct = 0;
						2:       stall_pct = 25;
						3:       stall_pct = 50;
						default: stall_pct = 80;
					endcase
				end
				pattern_left--;
				rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// This checks each response word against the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		lookup_t want;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("unexpected response word, position", -1, longint'(rsp_if.position));
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_if.found !== want.found)
					report_mismatch("found", longint'(want.found), longint'(rsp_if.found));
				if (rsp_if.position !== want.position)
					report_mismatch("position", longint'(want.position), longint'(rsp_if.position));
			end
		end
	end

	// The watchdog ends a hung run. It counts cycles in which neither channel nor the
	// register port moves a word.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (psel && penable && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		mismatch_count = 0;
		burst_left = 0;
		sender_idles = 1'b1;
		hold_request = 0;
		quiet_cycles = 0;
		count_mirror = '0;
		foreach (entry_mirror[i])
			entry_mirror[i] = '0;

		arst_n             <= 1'b0;
		req_if.valid       <= 1'b0;
		req_if.opcode      <= stsb_pkg::OP_WRITE;
		req_if.entry_index <= '0;
		req_if.data_value  <= '0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_lookups();
		test_full_table();
		test_backpressure();
		test_random_phases();

		drain_lookups();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_lookups.size() != 0)
			report_mismatch("outstanding search results", 0, pending_lookups.size());

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
